[rtl/conv2d_valid_multichannel_assert.svh]
// Assertion macros shared by the convolution RTL.
// Depends on a clock named clk and a reset named rst in the using scope.
`ifndef CONV2D_VALID_MULTICHANNEL_ASSERT_SVH
`define CONV2D_VALID_MULTICHANNEL_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cdv_pkg.sv]
// Types and codes shared by the convolution block.
// No dependencies.
package cdv_pkg;

  localparam logic [1:0] FUNC_WEIGHT = 2'd0;
  localparam logic [1:0] FUNC_BIAS   = 2'd1;
  localparam logic [1:0] FUNC_SAMPLE = 2'd2;

  localparam logic [2:0] REG_FILTERS  = 3'd0;
  localparam logic [2:0] REG_KERNEL   = 3'd1;
  localparam logic [2:0] REG_CHANNELS = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_SAMPLE
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [14:0]        addr;
    logic signed [15:0] value;
    logic               fstart;
  } item_t;

  typedef struct packed {
    logic signed [39:0] sum;
    logic [5:0]         filt;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               last;
  } res_t;

  // Clamped configuration as the engine uses it.
  typedef struct packed {
    logic [6:0] nf;
    logic [1:0] k;
    logic [5:0] nc;
    logic [8:0] w;
    logic [8:0] h;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } eng_state_t;

endpackage

[rtl/cdv_front.sv]
// Input queue: accepts items, classifies them and drops those with no effect.
// Depends on cdv_pkg.
module cdv_front #(
  parameter int WDEPTH = 18432,
  parameter int NFILT  = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic [14:0]        address,
  input  logic signed [15:0] value,
  input  logic               frame_start,
  output logic               q_valid,
  output cdv_pkg::item_t     q_item,
  input  logic               q_take
);

  localparam int DEPTH = 4;

  cdv_pkg::item_t mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       keep;
  logic       acc;
  cdv_pkg::item_t item;

  always_comb begin
    item.addr   = address;
    item.value  = value;
    item.fstart = frame_start;
    item.cmd    = cdv_pkg::CMD_SAMPLE;
    keep        = 1'b0;
    unique case (func)
      cdv_pkg::FUNC_WEIGHT: begin
        item.cmd = cdv_pkg::CMD_WEIGHT;
        keep     = ({17'd0, address} < WDEPTH);
      end
      cdv_pkg::FUNC_BIAS: begin
        item.cmd = cdv_pkg::CMD_BIAS;
        keep     = ({17'd0, address} < NFILT);
      end
      cdv_pkg::FUNC_SAMPLE: begin
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full    = (count == 3'(DEPTH));
  assign acc     = push && !full && keep;
  assign q_valid = (count != 3'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (acc) wr_ptr <= wr_ptr + 2'd1;
      if (q_take) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(acc) - 3'(q_take);
    end
  end

endmodule

[rtl/cdv_ofifo.sv]
// Result queue between the engine and the result ports.
// Depends on cdv_pkg.
module cdv_ofifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  cdv_pkg::res_t  wdata,
  output logic           space,
  output logic           empty,
  input  logic           pop,
  output cdv_pkg::res_t  rdata
);

  localparam int DEPTH = 4;

  cdv_pkg::res_t mem [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       rd;

  assign space = (count != 3'(DEPTH));
  assign empty = (count == 3'd0);
  assign rd    = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 2'd1;
      if (rd) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(wr) - 3'(rd);
    end
  end

endmodule

[rtl/cdv_engine.sv]
// Back end: weight, bias and row memories, position counters and one MAC.
// Depends on cdv_pkg.
module cdv_engine #(
  parameter int MAX_FILTERS  = 64,
  parameter int MAX_KERNEL   = 3,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_WIDTH    = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  cdv_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  cdv_pkg::item_t q_item,
  output logic           q_take,
  input  logic           res_space,
  output logic           res_push,
  output cdv_pkg::res_t  res
);

  localparam int WDEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int RDEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int FAW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int KSW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CMW    = $clog2(MAX_WIDTH);
  localparam int CHW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [15:0] wmem [WDEPTH];
  logic signed [15:0] bmem [MAX_FILTERS];
  logic signed [15:0] rmem [RDEPTH];

  cdv_pkg::eng_state_t state, state_next;

  // Position counters and their images modulo the store dimensions.
  logic [7:0]     row_cnt, col_cnt;
  logic [4:0]     ch_cnt;
  logic [KSW-1:0] slot;
  logic [CMW-1:0] colm;
  logic [CHW-1:0] chm;

  // Window walk.
  logic [6:0]     f;
  logic [1:0]     ki, kj;
  logic [4:0]     c;
  logic [WAW-1:0] wptr;
  logic [KSW-1:0] rslot, slot0;
  logic [CMW-1:0] rcolm, colm0;
  logic [7:0]     orow, ocol;
  logic           init;

  // MAC pipeline.
  logic               v1, v2;
  logic signed [15:0] w_q, r_q, b_q;
  logic signed [31:0] prod;
  logic signed [39:0] acc;

  // Effective counters of the item at the head of the queue.
  logic [7:0]     e_row, e_col;
  logic [4:0]     e_ch;
  logic [KSW-1:0] e_slot;
  logic [CMW-1:0] e_colm;
  logic [CHW-1:0] e_chm;
  logic           last_ch, win, col_end, row_end;
  logic           take_sample, issue, mac_done;
  int             t_slot, t_colm;

  function automatic logic [RAW-1:0] row_addr(input logic [KSW-1:0] s,
                                              input logic [CMW-1:0] cm,
                                              input logic [CHW-1:0] ch);
    logic [31:0] a;
    a = (32'(s) * MAX_WIDTH + 32'(cm)) * MAX_CHANNELS + 32'(ch);
    return a[RAW-1:0];
  endfunction

  always_comb begin
    e_row   = q_item.fstart ? 8'd0 : row_cnt;
    e_col   = q_item.fstart ? 8'd0 : col_cnt;
    e_ch    = q_item.fstart ? 5'd0 : ch_cnt;
    e_slot  = q_item.fstart ? '0 : slot;
    e_colm  = q_item.fstart ? '0 : colm;
    e_chm   = q_item.fstart ? '0 : chm;
    last_ch = (6'(e_ch) + 6'd1 >= cfg.nc);
    win     = last_ch && (9'(e_row) + 9'd1 >= 9'(cfg.k))
                      && (9'(e_col) + 9'd1 >= 9'(cfg.k));
    col_end = (9'(e_col) + 9'd1 >= cfg.w);
    row_end = (9'(e_row) + 9'd1 >= cfg.h);
    // Store slot and column of the window's top-left corner.
    t_slot  = int'(e_slot) - int'(cfg.k) + 1;
    if (t_slot < 0) t_slot = t_slot + MAX_KERNEL;
    t_colm  = int'(e_colm) - int'(cfg.k) + 1;
    if (t_colm < 0) t_colm = t_colm + MAX_WIDTH;
  end

  assign q_take      = (state == cdv_pkg::ST_IDLE) && q_valid;
  assign take_sample = q_take && (q_item.cmd == cdv_pkg::CMD_SAMPLE);
  assign issue       = (state == cdv_pkg::ST_MAC);
  assign mac_done    = (6'(c) + 6'd1 >= cfg.nc) && (kj + 2'd1 >= cfg.k)
                       && (ki + 2'd1 >= cfg.k);

  always_comb begin
    state_next = state;
    res_push   = 1'b0;
    unique case (state)
      cdv_pkg::ST_IDLE:  if (take_sample && win) state_next = cdv_pkg::ST_BIAS;
      cdv_pkg::ST_BIAS:  state_next = cdv_pkg::ST_MAC;
      cdv_pkg::ST_MAC:   if (mac_done) state_next = cdv_pkg::ST_DRAIN;
      cdv_pkg::ST_DRAIN: if (!v1 && !v2) state_next = cdv_pkg::ST_EMIT;
      cdv_pkg::ST_EMIT: begin
        if (res_space) begin
          res_push   = 1'b1;
          state_next = (f + 7'd1 == cfg.nf) ? cdv_pkg::ST_IDLE : cdv_pkg::ST_BIAS;
        end
      end
      default: state_next = cdv_pkg::ST_IDLE;
    endcase
  end

  assign res.sum  = acc;
  assign res.filt = f[5:0];
  assign res.row  = orow;
  assign res.col  = ocol;
  assign res.last = (f + 7'd1 == cfg.nf);

  always_ff @(posedge clk) begin
    if (rst) state <= cdv_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (q_take && q_item.cmd == cdv_pkg::CMD_WEIGHT) wmem[WAW'(q_item.addr)] <= q_item.value;
    if (q_take && q_item.cmd == cdv_pkg::CMD_BIAS) bmem[FAW'(q_item.addr)] <= q_item.value;
    if (take_sample) rmem[row_addr(e_slot, e_colm, e_chm)] <= q_item.value;
    if (issue) begin
      w_q <= wmem[wptr];
      r_q <= rmem[row_addr(rslot, rcolm, CHW'(c))];
    end
    if (state == cdv_pkg::ST_BIAS) b_q <= bmem[FAW'(f)];
  end

  // Position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      ch_cnt  <= '0;
      slot    <= '0;
      colm    <= '0;
      chm     <= '0;
    end else if (take_sample) begin
      row_cnt <= e_row;
      col_cnt <= e_col;
      ch_cnt  <= e_ch + 5'd1;
      slot    <= e_slot;
      colm    <= e_colm;
      chm     <= (e_chm == CHW'(MAX_CHANNELS - 1)) ? '0 : e_chm + CHW'(1);
      if (last_ch) begin
        ch_cnt <= '0;
        chm    <= '0;
        if (col_end) begin
          col_cnt <= '0;
          colm    <= '0;
          if (row_end) begin
            row_cnt <= '0;
            slot    <= '0;
          end else begin
            row_cnt <= e_row + 8'd1;
            slot    <= (e_slot == KSW'(MAX_KERNEL - 1)) ? '0 : e_slot + KSW'(1);
          end
        end else begin
          col_cnt <= e_col + 8'd1;
          colm    <= (e_colm == CMW'(MAX_WIDTH - 1)) ? '0 : e_colm + CMW'(1);
        end
      end
    end
  end

  // Window walk: filter, kernel row, kernel column, channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      init <= 1'b0;
    end else begin
      init <= 1'b0;
      if (take_sample && win) begin
        f     <= '0;
        wptr  <= '0;
        orow  <= e_row + 8'd1 - 8'(cfg.k);
        ocol  <= e_col + 8'd1 - 8'(cfg.k);
        slot0 <= KSW'(t_slot);
        colm0 <= CMW'(t_colm);
      end
      if (state == cdv_pkg::ST_BIAS) begin
        init  <= 1'b1;
        ki    <= '0;
        kj    <= '0;
        c     <= '0;
        rslot <= slot0;
        rcolm <= colm0;
      end
      if (issue) begin
        wptr <= wptr + WAW'(1);
        if (6'(c) + 6'd1 >= cfg.nc) begin
          c <= '0;
          if (kj + 2'd1 >= cfg.k) begin
            kj    <= '0;
            rcolm <= colm0;
            ki    <= ki + 2'd1;
            rslot <= (rslot == KSW'(MAX_KERNEL - 1)) ? '0 : rslot + KSW'(1);
          end else begin
            kj    <= kj + 2'd1;
            rcolm <= (rcolm == CMW'(MAX_WIDTH - 1)) ? '0 : rcolm + CMW'(1);
          end
        end else begin
          c <= c + 5'd1;
        end
      end
      if (res_push) f <= f + 7'd1;
    end
  end

  // Multiply then accumulate, one product per cycle while the engine is in its MAC state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) prod <= w_q * r_q;
    if (init) acc <= {{12{b_q[15]}}, b_q, 12'd0};
    else if (v2) acc <= acc + 40'(prod);
  end

endmodule

[rtl/conv2d_valid_multichannel.sv]
// Streaming 2-D convolution, valid padding, stride 1, over multi-channel samples.
// Writes and samples that complete no window are taken by the engine while it is idle.
// A completing sample holds the engine while one MAC walks the window for each filter.
// Reset (rst, synchronous, high) clears counters and queues; memories keep contents.
`include "conv2d_valid_multichannel_assert.svh"
module conv2d_valid_multichannel #(
  parameter int MAX_FILTERS  = 64,
  parameter int MAX_KERNEL   = 3,
  parameter int MAX_CHANNELS = 32,
  parameter int MAX_WIDTH    = 256
) (
  input  logic               clk,
  input  logic               rst,
  // Item channel: one beat per item.
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic [14:0]        address,
  input  logic signed [15:0] value,
  input  logic               frame_start,
  // Result channel: one beat per filter sum.
  output logic               empty,
  input  logic               pop,
  output logic signed [39:0] conv_sum,
  output logic [5:0]         filter_index,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic               last_of_run,
  // Configuration write channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int WDEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int CMAX   = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;
  localparam int WMAX   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int KMAX   = (MAX_KERNEL < 3) ? MAX_KERNEL : 3;

  // Raw configuration registers, kept at their written widths.
  logic [6:0] filter_count;
  logic [1:0] kernel_side;
  logic [5:0] channel_count;
  logic [8:0] img_width;
  logic [8:0] img_height;

  cdv_pkg::cfg_t  cfg;
  cdv_pkg::item_t q_item;
  cdv_pkg::res_t  res, head;
  logic q_valid, q_take, res_space, res_push;

  // The port never stalls a configuration beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_count  <= 7'd32;
      kernel_side   <= 2'd2;
      channel_count <= 6'd3;
      img_width     <= 9'd256;
      img_height    <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cdv_pkg::REG_FILTERS:  filter_count  <= cfg_data[6:0];
        cdv_pkg::REG_KERNEL:   kernel_side   <= cfg_data[1:0];
        cdv_pkg::REG_CHANNELS: channel_count <= cfg_data[5:0];
        cdv_pkg::REG_WIDTH:    img_width     <= cfg_data;
        cdv_pkg::REG_HEIGHT:   img_height    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped into what the stores can hold.
  always_comb begin
    cfg.nf = (filter_count == 7'd0) ? 7'd1
           : (filter_count > 7'(MAX_FILTERS)) ? 7'(MAX_FILTERS) : filter_count;
    cfg.k  = (kernel_side == 2'd0) ? 2'd1
           : (kernel_side > 2'(KMAX)) ? 2'(KMAX) : kernel_side;
    cfg.nc = (channel_count == 6'd0) ? 6'd1
           : (channel_count > 6'(CMAX)) ? 6'(CMAX) : channel_count;
    cfg.w  = (img_width == 9'd0) ? 9'd1
           : (img_width > 9'(WMAX)) ? 9'(WMAX) : img_width;
    cfg.h  = (img_height == 9'd0) ? 9'd1
           : (img_height > 9'd256) ? 9'd256 : img_height;
  end

  // Front: accepts items, drops writes that land outside the stores and unused function codes.
  cdv_front #(
    .WDEPTH (WDEPTH),
    .NFILT  (MAX_FILTERS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .address     (address),
    .value       (value),
    .frame_start (frame_start),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take)
  );

  // Back: stores, counters and the multiply-accumulate walk.
  cdv_engine #(
    .MAX_FILTERS  (MAX_FILTERS),
    .MAX_KERNEL   (MAX_KERNEL),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .res_space (res_space),
    .res_push  (res_push),
    .res       (res)
  );

  // Finished sums wait here, so the engine keeps going while results stall, until the queue is full.
  cdv_ofifo u_ofifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res),
    .space (res_space),
    .empty (empty),
    .pop   (pop),
    .rdata (head)
  );

  assign conv_sum     = head.sum;
  assign filter_index = head.filt;
  assign out_row      = head.row;
  assign out_col      = head.col;
  assign last_of_run  = head.last;

  // The engine only writes a sum into the result queue when there is room.
  `CDV_ASSERT_NOW(a_push_room, res_push, res_space, "sum written into a full result queue")
  // A zero filter count is clamped to one filter.
  `CDV_ASSERT_NEXT(a_clamp_nf, cfg_valid && cfg_index == cdv_pkg::REG_FILTERS && cfg_data == 9'd0, cfg.nf == 7'd1, "filter count not clamped")
  // With no new sum the result queue cannot become non-empty.
  `CDV_ASSERT_NEXT(a_empty_hold, empty && !res_push, empty, "result appeared from nowhere")

endmodule
